/* hdl/bam_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_pkg: shared definitions for the bit-parallel approximate matcher
// Request kinds, register indexes, default sizes and the configuration bundle.
// ----------------------------------------------------------------------------
package bam_pkg;

    localparam int DEF_ERROR_LEVELS = 4;
    localparam int DEF_PATTERN_BITS = 32;

    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = 8;
    localparam int MASK_W      = 32;

    localparam logic [MASK_W-1:0] LIVE_RESET = 32'h8000_0000;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STEP  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        CFG_SKIP   = 2'd0,
        CFG_ACCEPT = 2'd1,
        CFG_LIVE   = 2'd2,
        CFG_ERRORS = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [MASK_W-1:0] skip_mask;
        logic [MASK_W-1:0] accept_mask;
        logic [MASK_W-1:0] live_mask;
        logic [1:0]        max_errors;
    } cfg_t;

endpackage

/* hdl/bam_char_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_char_table: character class table
// 256-entry memory with registered read data and per-entry valid bits, so
// that entries never loaded since reset read as zero.
// ----------------------------------------------------------------------------
module bam_char_table #(
    parameter int PATTERN_BITS = bam_pkg::DEF_PATTERN_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic                         rd_en,
    input  logic [bam_pkg::TABLE_AW-1:0] addr,
    input  logic [PATTERN_BITS-1:0]      wr_data,
    output logic [PATTERN_BITS-1:0]      rd_data
);

    logic [PATTERN_BITS-1:0]         mem_reg [bam_pkg::TABLE_DEPTH];
    logic [bam_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [PATTERN_BITS-1:0]         rd_data_reg;
    logic                            rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= valid_reg[addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

/* hdl/bam_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_step: next-state logic for the error-level vectors
// Advances the used levels by one text byte (clearing the rest), restarts or
// holds them, and flags whether any used level reaches the accept position.
// ----------------------------------------------------------------------------
module bam_step #(
    parameter int ERROR_LEVELS = bam_pkg::DEF_ERROR_LEVELS,
    parameter int PATTERN_BITS = bam_pkg::DEF_PATTERN_BITS
) (
    input  bam_pkg::func_t                            func,
    input  bam_pkg::cfg_t                             cfg,
    input  logic [PATTERN_BITS-1:0]                   char_bits,
    input  logic [ERROR_LEVELS-1:0][PATTERN_BITS-1:0] levels,
    output logic [ERROR_LEVELS-1:0][PATTERN_BITS-1:0] levels_next,
    output logic                                      accepted
);

    localparam logic [PATTERN_BITS-1:0] START_BIT = {1'b1, {(PATTERN_BITS-1){1'b0}}};

    logic [PATTERN_BITS-1:0]                   ep;
    logic [PATTERN_BITS-1:0]                   live;
    logic [PATTERN_BITS-1:0]                   acc;
    logic [PATTERN_BITS-1:0]                   hit_vec;
    logic [ERROR_LEVELS-1:0][PATTERN_BITS-1:0] adv;

    always_comb begin
        ep   = PATTERN_BITS'(cfg.skip_mask);
        live = PATTERN_BITS'(cfg.live_mask);
        acc  = PATTERN_BITS'(cfg.accept_mask);

        // Exact level: stay on a space position, or advance on a match.
        adv[0]  = (levels[0] & ep) | ((levels[0] & char_bits) >> 1);
        hit_vec = adv[0] & acc;

        // Each error level also takes substitutions and insertions from the
        // old level below and deletions from the new level below.
        for (int i = 1; i < ERROR_LEVELS; i++) begin
            if (i <= int'(cfg.max_errors)) begin
                adv[i] = ((levels[i] & ep) | ((levels[i] & char_bits) >> 1)
                         | levels[i-1] | (levels[i-1] >> 1) | (adv[i-1] >> 1)) & live;
            end else begin
                adv[i] = '0;
            end
            hit_vec = hit_vec | (adv[i] & acc);
        end
    end

    always_comb begin
        levels_next = levels;
        accepted    = 1'b0;
        case (func)
            bam_pkg::FUNC_STEP: begin
                levels_next = adv;
                accepted    = |hit_vec;
            end
            bam_pkg::FUNC_START: begin
                levels_next    = '0;
                levels_next[0] = START_BIT;
            end
            default: begin
                levels_next = levels;
            end
        endcase
    end

endmodule

/* hdl/bitparallel_approx_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitparallel_approx_matcher: anchored bit-parallel approximate matcher
// Keeps one bit vector per error level and advances them on each text byte,
// reporting whether the pattern would be accepted if the string ended there.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Carries
//  s_        in         s_tvalid / s_tready   func (tuser), char_code, class_mask
//  m_        out        m_tvalid / m_tready   accepted
//  cfg_      in         cfg_valid / cfg_ready register index and write data
//
// One request is taken per clock cycle while s_tready is high. An accepted
// request first reads the character table memory into its registered read
// port, then updates the level vectors into the result register. The table's
// valid bits clear in the reset cycle itself, so the block takes requests
// right after reset. When m_tready stays low the two stages fill and s_tready
// drops; nothing is lost or repeated.
//
module bitparallel_approx_matcher #(
    parameter int ERROR_LEVELS = bam_pkg::DEF_ERROR_LEVELS,
    parameter int PATTERN_BITS = bam_pkg::DEF_PATTERN_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [39:0]                s_tdata,   // [7:0] char_code, [39:8] class_mask
    input  logic [1:0]                 s_tuser,   // [1:0] func

    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [0] accepted, [7:1] zero

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [bam_pkg::MASK_W-1:0] cfg_data
);

    localparam logic [PATTERN_BITS-1:0] START_BIT = {1'b1, {(PATTERN_BITS-1){1'b0}}};

    // Configuration registers.
    bam_pkg::cfg_t cfg_reg;

    // Input side: decoded request fields.
    bam_pkg::func_t                s_func;
    logic [bam_pkg::TABLE_AW-1:0]  s_char_code;
    logic [bam_pkg::MASK_W-1:0]    s_class_mask;
    logic                          s_accept;

    // First stage holds the request kind while the table read completes.
    logic           s1_valid_reg;
    bam_pkg::func_t s1_func_reg;
    logic           s1_adv;

    // Result register and the level vectors updated along with it.
    logic                                      m_valid_reg;
    logic                                      m_accepted_reg;
    logic                                      out_free;
    logic [ERROR_LEVELS-1:0][PATTERN_BITS-1:0] levels_reg;
    logic [ERROR_LEVELS-1:0][PATTERN_BITS-1:0] levels_next;
    logic                                      accepted_next;
    logic [PATTERN_BITS-1:0]                   char_bits;

    assign s_func       = bam_pkg::func_t'(s_tuser);
    assign s_char_code  = s_tdata[7:0];
    assign s_class_mask = s_tdata[39:8];

    // The result register frees when empty or when its result is taken; the
    // first stage can then move on, and so can the input.
    assign out_free  = !m_valid_reg || m_tready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign s_tready  = !s1_valid_reg || out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // The live mask resets to the pattern start bit as seen through the
    // register width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.skip_mask   <= '0;
            cfg_reg.accept_mask <= '0;
            cfg_reg.live_mask   <= bam_pkg::MASK_W'(START_BIT);
            cfg_reg.max_errors  <= '0;
        end else if (cfg_valid) begin
            case (bam_pkg::cfg_index_t'(cfg_index))
                bam_pkg::CFG_SKIP:   cfg_reg.skip_mask   <= cfg_data;
                bam_pkg::CFG_ACCEPT: cfg_reg.accept_mask <= cfg_data;
                bam_pkg::CFG_LIVE:   cfg_reg.live_mask   <= cfg_data;
                bam_pkg::CFG_ERRORS: cfg_reg.max_errors  <= cfg_data[1:0];
                default:             cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Table loads write at acceptance; a byte step reads its entry at the
    // same point, so a step right behind a load already sees the new entry.
    bam_char_table #(
        .PATTERN_BITS (PATTERN_BITS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_accept && (s_func == bam_pkg::FUNC_LOAD)),
        .rd_en   (s_accept && (s_func == bam_pkg::FUNC_STEP)),
        .addr    (s_char_code),
        .wr_data (PATTERN_BITS'(s_class_mask)),
        .rd_data (char_bits)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_func_reg  <= bam_pkg::FUNC_LOAD;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
                s1_func_reg  <= s_func;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    bam_step #(
        .ERROR_LEVELS (ERROR_LEVELS),
        .PATTERN_BITS (PATTERN_BITS)
    ) u_step (
        .func        (s1_func_reg),
        .cfg         (cfg_reg),
        .char_bits   (char_bits),
        .levels      (levels_reg),
        .levels_next (levels_next),
        .accepted    (accepted_next)
    );

    // The level vectors change only as a request moves into the result
    // register, so each request sees the state left by the one before it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            m_accepted_reg <= 1'b0;
            levels_reg     <= '0;
            levels_reg[0]  <= START_BIT;
        end else begin
            if (s1_adv) begin
                m_valid_reg    <= 1'b1;
                m_accepted_reg <= accepted_next;
                levels_reg     <= levels_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_accepted_reg};

    // An accepted result means some level was left holding the accept bit, so the level vectors cannot all be empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_accepted_reg |-> (|levels_reg))
    else $error("accepted result with all level vectors empty");

    // A string start leaves only the exact level at its start position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv && (s1_func_reg == bam_pkg::FUNC_START)
        |=> (levels_reg[0] == START_BIT) && !m_accepted_reg)
    else $error("string start did not restart the level vectors");

    // Only a byte step can report acceptance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv && (s1_func_reg != bam_pkg::FUNC_STEP) |=> !m_accepted_reg)
    else $error("acceptance reported for a request that is not a byte step");

endmodule

/* verif/bam_accept_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_accept_monitor: prediction and result check for the approximate matcher
// Watches the request, result and register channels, keeps its own copy of
// the character table, level vectors and registers, and compares every result
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module bam_accept_monitor (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [39:0]                s_tdata,   // [7:0] char_code, [39:8] class_mask
    input  logic [1:0]                 s_tuser,   // [1:0] func

    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [7:0]                 m_tdata,   // [0] accepted, [7:1] zero

    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [bam_pkg::MASK_W-1:0] cfg_data,

    output int                         fail_count,
    output int                         n_pending
);

    localparam int LEVELS = bam_pkg::DEF_ERROR_LEVELS;

    bam_pkg::cfg_t              regs;
    logic [bam_pkg::MASK_W-1:0] char_masks [bam_pkg::TABLE_DEPTH];
    logic [bam_pkg::MASK_W-1:0] level_vec [LEVELS];
    logic                       accept_q [$];

    function automatic void restart_levels();
        level_vec[0] = bam_pkg::LIVE_RESET;
        for (int i = 1; i < LEVELS; i++) level_vec[i] = '0;
    endfunction

    function automatic void reset_model();
        regs.skip_mask   = '0;
        regs.accept_mask = '0;
        regs.live_mask   = bam_pkg::LIVE_RESET;
        regs.max_errors  = '0;
        for (int i = 0; i < bam_pkg::TABLE_DEPTH; i++) char_masks[i] = '0;
        restart_levels();
    endfunction

    // Advances the used levels by one text byte, clears the rest, and reports
    // whether any used level holds the accept position afterwards.
    function automatic logic advance_levels(input logic [7:0] code);
        logic [bam_pkg::MASK_W-1:0] hit_bits, cur, nxt, prev_old, prev_new, sp;
        int                         used;
        used = int'(regs.max_errors);
        if (used > LEVELS - 1) used = LEVELS - 1;
        sp       = char_masks[code];
        cur      = level_vec[0];
        nxt      = (cur & regs.skip_mask) | ((cur & sp) >> 1);
        level_vec[0] = nxt;
        hit_bits = nxt & regs.accept_mask;
        prev_old = cur;
        prev_new = nxt;
        for (int i = 1; i < LEVELS; i++) begin
            if (i <= used) begin
                cur = level_vec[i];
                nxt = ((cur & regs.skip_mask) | ((cur & sp) >> 1) | prev_old
                       | (prev_old >> 1) | (prev_new >> 1)) & regs.live_mask;
                level_vec[i] = nxt;
                hit_bits |= nxt & regs.accept_mask;
                prev_old = cur;
                prev_new = nxt;
            end else begin
                level_vec[i] = '0;
            end
        end
        return |hit_bits;
    endfunction

    function automatic logic predict_accept(input logic [1:0] func,
                                            input logic [7:0] code,
                                            input logic [bam_pkg::MASK_W-1:0] cls);
        if (func == bam_pkg::FUNC_LOAD) begin
            char_masks[code] = cls;
            return 1'b0;
        end
        if (func == bam_pkg::FUNC_START) begin
            restart_levels();
            return 1'b0;
        end
        if (func == bam_pkg::FUNC_STEP) return advance_levels(code);
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        logic exp_acc;
        int   bad;
        bad = 0;
        if (!aresetn) begin
            reset_model();
            accept_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (bam_pkg::cfg_index_t'(cfg_index))
                    bam_pkg::CFG_SKIP:   regs.skip_mask   = cfg_data;
                    bam_pkg::CFG_ACCEPT: regs.accept_mask = cfg_data;
                    bam_pkg::CFG_LIVE:   regs.live_mask   = cfg_data;
                    bam_pkg::CFG_ERRORS: regs.max_errors  = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (accept_q.size() == 0) begin
                    $error("accepted: expected none, actual %0d", m_tdata[0]);
                    bad++;
                end else begin
                    exp_acc = accept_q.pop_front();
                    if (m_tdata[0] !== exp_acc) begin
                        $error("accepted: expected %0d, actual %0d", exp_acc, m_tdata[0]);
                        bad++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                accept_q.push_back(predict_accept(s_tuser, s_tdata[7:0], s_tdata[39:8]));
        end
        n_pending <= accept_q.size();
        if (bad != 0) fail_count <= fail_count + bad;
    end

endmodule

/* verif/bitparallel_approx_matcher_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitparallel_approx_matcher_tb: regression for the approximate matcher
// Loads character tables for random patterns, programs the registers and
// streams strings that follow the pattern with random edits, mixed with noise
// requests, under random gaps on both channels and long result stalls in phases 2 and 9.
// ----------------------------------------------------------------------------
module bitparallel_approx_matcher_tb;

    // The func field has one code that the block treats as a no-op.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int ITEM_TARGET  = 1520;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 250;
    localparam int CYCLE_LIMIT  = 400000;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [39:0]                s_tdata;   // [7:0] char_code, [39:8] class_mask
    logic [1:0]                 s_tuser;   // [1:0] func
    logic                       m_tvalid;
    logic                       m_tready;
    logic [7:0]                 m_tdata;   // [0] accepted, [7:1] zero
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index;
    logic [bam_pkg::MASK_W-1:0] cfg_data;

    int          fail_count;
    int          n_pending;
    int          items_sent;
    int unsigned cycle_count;

    // Shared between the request and result processes: quiet removes all
    // random gaps, hold_req asks the result side for one long stall.
    bit quiet;
    bit hold_req;

    bitparallel_approx_matcher u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bam_accept_monitor u_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .n_pending  (n_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("bitparallel_approx_matcher regression: fail");
        $finish;
    end

    // Result side. Each result waits a random number of cycles before ready
    // goes high, unless quiet is set. A pending hold_req inserts one long
    // stall so that both pipeline stages fill and the input stalls too.
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end
            gap = quiet ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Offers one request after a random gap and returns at the edge where it
    // was taken. Valid stays high when the next request follows without a gap.
    task automatic send_item(input logic [1:0] func, input logic [7:0] code,
                             input logic [bam_pkg::MASK_W-1:0] cls);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {cls, code};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Stops offering requests and waits until every predicted result has come
    // back, then waits out a drain interval for anything still inside the pipeline.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(input bam_pkg::cfg_index_t idx,
                             input logic [bam_pkg::MASK_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [bam_pkg::MASK_W-1:0] skip_v,
                             input logic [bam_pkg::MASK_W-1:0] acc_v,
                             input logic [bam_pkg::MASK_W-1:0] live_v,
                             input logic [1:0] errs_v);
        write_reg(bam_pkg::CFG_SKIP, skip_v);
        write_reg(bam_pkg::CFG_ACCEPT, acc_v);
        write_reg(bam_pkg::CFG_LIVE, live_v);
        write_reg(bam_pkg::CFG_ERRORS, {30'd0, errs_v});
    endtask

    // Short directed opening: empty table, extreme codes and masks, the no-op
    // func code, and max_errors lowered and raised in the middle of a string.
    task automatic run_directed();
        send_item(bam_pkg::FUNC_STEP, 8'h41, '1);
        send_item(bam_pkg::FUNC_LOAD, 8'h00, '1);
        send_item(bam_pkg::FUNC_LOAD, 8'hFF, '1);
        send_item(bam_pkg::FUNC_LOAD, 8'h55, '0);
        write_all('0, 32'h4000_0000, '1, 2'd3);
        send_item(bam_pkg::FUNC_START, 8'h00, '0);
        send_item(bam_pkg::FUNC_STEP, 8'h00, '0);
        send_item(bam_pkg::FUNC_STEP, 8'hFF, '1);
        send_item(FUNC_UNUSED, 8'hFF, '1);
        send_item(bam_pkg::FUNC_STEP, 8'h55, '0);
        // Dropping the error levels mid-string clears them; raising the count
        // again lets them restart from zero.
        write_reg(bam_pkg::CFG_ERRORS, 32'd0);
        send_item(bam_pkg::FUNC_STEP, 8'h00, '1);
        write_reg(bam_pkg::CFG_ERRORS, 32'd3);
        send_item(bam_pkg::FUNC_STEP, 8'hFF, '0);
        write_reg(bam_pkg::CFG_SKIP, '1);
        write_reg(bam_pkg::CFG_ACCEPT, '1);
        send_item(bam_pkg::FUNC_STEP, 8'h00, '1);
        send_item(bam_pkg::FUNC_START, 8'hFF, '1);
        send_item(bam_pkg::FUNC_STEP, 8'hFF, '1);
        write_all('0, '0, '0, 2'd0);
        send_item(bam_pkg::FUNC_STEP, 8'h00, '0);
        send_item(bam_pkg::FUNC_LOAD, 8'h00, '0);
        send_item(bam_pkg::FUNC_STEP, 8'h00, '1);
    endtask

    // One random phase: pick a pattern over a small random alphabet, program
    // the registers for it (or an extreme or random setting), load its table
    // entries and stream a few strings, most following the pattern with random edits.
    task automatic run_phase(input int phase_no);
        logic [7:0]                 alpha [6];
        int                         pidx [30];
        int                         plen, nstr, r, k, j;
        logic [bam_pkg::MASK_W-1:0] skip_v, acc_v, live_v, cls;
        logic [1:0]                 errs_v;
        quiet = ($urandom_range(0, 3) == 0);
        for (k = 0; k < 6; k++) alpha[k] = 8'($urandom_range(0, 255));
        plen   = $urandom_range(1, 30);
        skip_v = '0;
        // Alphabet entry zero plays the role of a space in the pattern.
        for (j = 0; j < plen; j++) begin
            pidx[j] = $urandom_range(0, 5);
            if (pidx[j] == 0) skip_v[31-j] = 1'b1;
        end
        acc_v  = 32'h8000_0000 >> plen;
        live_v = ~(32'hFFFF_FFFF >> (plen + 1));
        errs_v = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0: begin
                skip_v = '0; acc_v = '0; live_v = '0; errs_v = 2'd0;
            end
            1: begin
                skip_v = '1; acc_v = '1; live_v = '1; errs_v = 2'd3;
            end
            2: begin
                skip_v = $urandom; acc_v = $urandom; live_v = $urandom;
            end
            default: ;
        endcase
        write_all(skip_v, acc_v, live_v, errs_v);

        for (k = 0; k < 6; k++) begin
            cls = '0;
            for (j = 0; j < plen; j++)
                if (alpha[pidx[j]] == alpha[k]) cls[31-j] = 1'b1;
            send_item(bam_pkg::FUNC_LOAD, alpha[k], cls);
        end

        if (phase_no == 2 || phase_no == 9) begin
            quiet    = 1'b1;
            hold_req = 1'b1;
        end

        nstr = $urandom_range(2, 5);
        repeat (nstr) begin
            send_item(bam_pkg::FUNC_START, 8'($urandom_range(0, 255)), $urandom);
            if ($urandom_range(0, 9) == 0) begin
                // A string of arbitrary bytes that ignores the pattern.
                repeat ($urandom_range(1, 8))
                    send_item(bam_pkg::FUNC_STEP, 8'($urandom_range(0, 255)), $urandom);
            end else begin
                for (j = 0; j < plen; j++) begin
                    r = $urandom_range(0, 23);
                    if (r == 0) begin
                        send_item(bam_pkg::FUNC_STEP, alpha[$urandom_range(0, 5)],
                                  $urandom);
                    end else if (r == 1) begin
                        send_item(bam_pkg::FUNC_STEP, alpha[$urandom_range(0, 5)],
                                  $urandom);
                        send_item(bam_pkg::FUNC_STEP, alpha[pidx[j]], $urandom);
                    end else if (r == 2) begin
                        // Deletion: this pattern character never arrives.
                    end else if (r == 3) begin
                        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                  $urandom);
                    end else begin
                        send_item(bam_pkg::FUNC_STEP, alpha[pidx[j]], $urandom);
                    end
                end
            end
            repeat ($urandom_range(0, 3))
                send_item(bam_pkg::FUNC_STEP, alpha[$urandom_range(0, 5)], $urandom);
        end
    endtask

    initial begin
        int phase_no;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= bam_pkg::FUNC_LOAD;
        cfg_valid <= 1'b0;
        cfg_index <= bam_pkg::CFG_SKIP;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            run_phase(phase_no);
            phase_no++;
        end

        // Let every outstanding result come back before judging the run.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && n_pending == 0) begin
            $display("bitparallel_approx_matcher regression: pass");
        end else begin
            $display("bitparallel_approx_matcher regression: fail");
        end
        $finish;
    end

endmodule

/* bitparallel_approx_matcher.f */
hdl/bam_pkg.sv
hdl/bam_char_table.sv
hdl/bam_step.sv
hdl/bitparallel_approx_matcher.sv
verif/bam_accept_monitor.sv
verif/bitparallel_approx_matcher_tb.sv
